### sv/aarm_pkg.sv
package aarm_pkg;

	// default parameter values
	localparam int TRIG_ITER_DEF = 16;
	localparam int OUT_FRAC_DEF  = 14;

	// word widths
	localparam int TW = 35; // angle word, Q.30
	localparam int CW = 34; // cosine, sine and products, Q.30
	localparam int UW = 32; // unit axis components, Q.30
	localparam int OW = 35; // one minus cosine
	localparam int EW = 40; // matrix entry before rounding

	// pipeline depths of the axis path
	localparam int SQ_STAGES  = 32;
	localparam int DIV_STAGES = 31;
	localparam int MAT_STAGES = 3;

	localparam logic signed [TW-1:0] Q_PI        = 35'sd3373259426;
	localparam logic signed [TW-1:0] Q_TWO_PI    = 35'sd6746518852;
	localparam logic signed [TW-1:0] Q_HALF_PI   = 35'sd1686629713;
	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [OW-1:0] QONE_O      = 35'sd1073741824;
	localparam logic signed [EW-1:0] QONE_E      = 40'sd1073741824;

	// axis sideband carried along the root and divide pipelines
	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic               zero;
	} axis_t;

	// arctangent of 2^-i in Q.30
	function automatic logic signed [TW-1:0] atan_step(input int i);
		case (i)
			0:  return 35'sh03243F6A8;
			1:  return 35'sh01DAC6705;
			2:  return 35'sh00FADBAFC;
			3:  return 35'sh007F56EA6;
			4:  return 35'sh003FEAB76;
			5:  return 35'sh001FFD55B;
			6:  return 35'sh000FFFAAA;
			7:  return 35'sh0007FFF55;
			8:  return 35'sh0003FFFEA;
			9:  return 35'sh0001FFFFD;
			10: return 35'sh0000FFFFF;
			11: return 35'sh00007FFFF;
			12: return 35'sh00003FFFF;
			13: return 35'sh00001FFFF;
			14: return 35'sh00000FFFF;
			15: return 35'sh000007FFF;
			default: begin
				if (i <= 30)
					return TW'(64'sd1 <<< (30 - i));
				return '0;
			end
		endcase
	endfunction

	// round half up to frac bits, saturate to +-1, clamp to 16 bits
	function automatic logic signed [15:0] to_out(input logic signed [EW-1:0] v, input int frac);
		logic signed [EW-1:0] r;
		logic signed [EW-1:0] lim;
		r = v;
		if (frac < 30)
			r = (v + (40'sd1 <<< (29 - frac))) >>> (30 - frac);
		lim = 40'sd1 <<< frac;
		if (r > lim)
			r = lim;
		if (r < -lim)
			r = -lim;
		if (r > 40'sd32767)
			r = 40'sd32767;
		if (r < -40'sd32768)
			r = -40'sd32768;
		return r[15:0];
	endfunction

endpackage

### sv/axis_angle_rotation_matrix.sv
// Axis-angle rotation matrix, 3x3 Rodrigues form.
// Input channel: drive angle (Q4.12 radians) and axis_x/y/z (any scale)
// with start high; a transaction is taken at a clock edge with start high
// and busy low. busy is always low, so a new transaction may enter every
// cycle.
// Output channel: done is high for exactly one cycle with the nine Q2.14
// entries and zero_axis; the entries are valid only in that cycle.
// A transaction passes in order through the squared-length register, the
// bit-pair square root, the three parallel one-bit-per-stage dividers and
// the products and rounding. The sine/cosine path (1 + TRIG_ITERATIONS
// stages) runs alongside and is delayed to meet the axis path.
// Throughput is one transaction per cycle, fixed by the pipeline.
// A zero axis gives the identity with zero_axis set.
// Reset clears all valid bits; in-flight transactions are dropped.
// The receiver cannot stall: every result is shown once and taken.
module axis_angle_rotation_matrix import aarm_pkg::*; #(
	parameter int TRIG_ITERATIONS = TRIG_ITER_DEF,
	parameter int OUT_FRAC_BITS   = OUT_FRAC_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] angle,
	input  logic signed [15:0] axis_x,
	input  logic signed [15:0] axis_y,
	input  logic signed [15:0] axis_z,
	output logic               done,
	output logic signed [15:0] row0_col0,
	output logic signed [15:0] row0_col1,
	output logic signed [15:0] row0_col2,
	output logic signed [15:0] row1_col0,
	output logic signed [15:0] row1_col1,
	output logic signed [15:0] row1_col2,
	output logic signed [15:0] row2_col0,
	output logic signed [15:0] row2_col1,
	output logic signed [15:0] row2_col2,
	output logic               zero_axis
);

	localparam int TDLY = SQ_STAGES + DIV_STAGES - TRIG_ITERATIONS;
	localparam int LAT  = 1 + SQ_STAGES + DIV_STAGES + MAT_STAGES;

	logic accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// squared axis length
	logic signed [31:0] sx, sy, sz;
	logic [31:0]        q;
	logic [31:0]        q_s1;
	axis_t              side_s1;
	logic               vld_s1;

	assign sx = axis_x * axis_x;
	assign sy = axis_y * axis_y;
	assign sz = axis_z * axis_z;
	assign q  = $unsigned(sx) + $unsigned(sy) + $unsigned(sz);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else
			vld_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		q_s1         <= q;
		side_s1.x    <= axis_x;
		side_s1.y    <= axis_y;
		side_s1.z    <= axis_z;
		side_s1.zero <= (q == '0);
	end

	// axis length
	logic        sq_done;
	logic [31:0] root;
	axis_t       sq_side;

	aarm_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (vld_s1),
		.q      (q_s1),
		.side   (side_s1),
		.done   (sq_done),
		.root   (root),
		.side_o (sq_side)
	);

	// unit axis
	logic                 dv_done, dv_zero;
	logic signed [UW-1:0] ux, uy, uz;

	aarm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_done),
		.m      (root),
		.side   (sq_side),
		.done   (dv_done),
		.ux     (ux),
		.uy     (uy),
		.uz     (uz),
		.zero   (dv_zero)
	);

	// sine and cosine, delayed to meet the axis path
	logic signed [CW-1:0] cosv, sinv;
	logic signed [CW-1:0] cdly_s [0:TDLY-1];
	logic signed [CW-1:0] sdly_s [0:TDLY-1];

	aarm_cordic #(
		.TRIG_ITERATIONS (TRIG_ITERATIONS)
	) u_cordic (
		.clk   (clk),
		.angle (angle),
		.cosv  (cosv),
		.sinv  (sinv)
	);

	always_ff @(posedge clk) begin
		cdly_s[0] <= cosv;
		sdly_s[0] <= sinv;
		for (int i = 1; i < TDLY; i++) begin
			cdly_s[i] <= cdly_s[i-1];
			sdly_s[i] <= sdly_s[i-1];
		end
	end

	// matrix entries
	aarm_matrix #(
		.OUT_FRAC_BITS (OUT_FRAC_BITS)
	) u_matrix (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (dv_done),
		.ux        (ux),
		.uy        (uy),
		.uz        (uz),
		.cosv      (cdly_s[TDLY-1]),
		.sinv      (sdly_s[TDLY-1]),
		.zero      (dv_zero),
		.done      (done),
		.row0_col0 (row0_col0),
		.row0_col1 (row0_col1),
		.row0_col2 (row0_col2),
		.row1_col0 (row1_col0),
		.row1_col1 (row1_col1),
		.row1_col2 (row1_col2),
		.row2_col0 (row2_col0),
		.row2_col1 (row2_col1),
		.row2_col2 (row2_col2),
		.zero_axis (zero_axis)
	);

`ifndef SYNTH
	// every result traces back to a transaction a fixed time earlier
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LAT))
		else $error("result without a matching transaction");

	// every transaction yields a result after the pipeline depth
	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LAT done)
		else $error("transaction lost in the pipeline");

	// zero axis: entries 01, 10 and 21 are zero and the diagonal entries are equal
	a_identity: assert property (@(posedge clk) disable iff (!arst_n)
		done && zero_axis |-> row0_col1 == 16'sd0 && row1_col0 == 16'sd0 &&
			row2_col1 == 16'sd0 && row0_col0 == row1_col1 && row1_col1 == row2_col2)
		else $error("zero axis result is not the identity");
`endif

endmodule

### sv/aarm_cordic.sv
module aarm_cordic import aarm_pkg::*; #(
	parameter int TRIG_ITERATIONS = TRIG_ITER_DEF
) (
	input  logic                 clk,
	input  logic signed [15:0]   angle,
	output logic signed [CW-1:0] cosv,
	output logic signed [CW-1:0] sinv
);

	localparam int T = TRIG_ITERATIONS;

	logic signed [TW-1:0] th0, th1, thf;
	logic                 negc;

	logic signed [CW-1:0] x_s [0:T];
	logic signed [CW-1:0] y_s [0:T];
	logic signed [TW-1:0] z_s [0:T];
	logic                 neg_s [0:T];

	// reduce into [-pi, pi], then fold into [-pi/2, pi/2]
	always_comb begin
		th0 = $signed({angle[15], angle, 18'b0});
		th1 = th0;
		for (int k = 0; k < 2; k++) begin
			if (th1 > Q_PI)
				th1 = th1 - Q_TWO_PI;
			if (th1 < -Q_PI)
				th1 = th1 + Q_TWO_PI;
		end
		negc = 1'b0;
		thf  = th1;
		if (th1 > Q_HALF_PI) begin
			thf  = Q_PI - th1;
			negc = 1'b1;
		end else if (th1 < -Q_HALF_PI) begin
			thf  = -Q_PI - th1;
			negc = 1'b1;
		end
	end

	// stage zero holds the folded angle
	always_ff @(posedge clk) begin
		x_s[0]   <= CORDIC_GAIN;
		y_s[0]   <= '0;
		z_s[0]   <= thf;
		neg_s[0] <= negc;
	end

	// one rotation step per stage
	for (genvar i = 0; i < T; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (z_s[i] >= 0) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - atan_step(i);
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + atan_step(i);
			end
			neg_s[i+1] <= neg_s[i];
		end
	end

	assign cosv = neg_s[T] ? -x_s[T] : x_s[T];
	assign sinv = y_s[T];

endmodule

### sv/aarm_isqrt.sv
module aarm_isqrt import aarm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] q,
	input  axis_t       side,
	output logic        done,
	output logic [31:0] root,
	output axis_t       side_o
);

	localparam int N = SQ_STAGES;

	logic [63:0] rem_s [1:N];
	logic [63:0] res_s [1:N];
	axis_t       side_s [1:N];
	logic        vld_s [1:N];

	// one result bit per stage, bit pair walks down from 2^62
	for (genvar k = 0; k < N; k++) begin : g_st
		logic [63:0] rv, rr, bitv, t;
		axis_t       sd;
		logic        vv;
		if (k == 0) begin : g_first
			assign rv = {2'b0, q, 30'b0};
			assign rr = '0;
			assign sd = side;
			assign vv = start;
		end else begin : g_next
			assign rv = rem_s[k];
			assign rr = res_s[k];
			assign sd = side_s[k];
			assign vv = vld_s[k];
		end
		assign bitv = 64'd1 << (62 - 2 * k);
		assign t    = rr + bitv;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k+1] <= 1'b0;
			else
				vld_s[k+1] <= vv;
		end

		always_ff @(posedge clk) begin
			if (rv >= t) begin
				rem_s[k+1] <= rv - t;
				res_s[k+1] <= (rr >> 1) + bitv;
			end else begin
				rem_s[k+1] <= rv;
				res_s[k+1] <= rr >> 1;
			end
			side_s[k+1] <= sd;
		end
	end

	assign done   = vld_s[N];
	assign root   = res_s[N][31:0];
	assign side_o = side_s[N];

endmodule

### sv/aarm_div.sv
module aarm_div import aarm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [31:0]          m,
	input  axis_t                side,
	output logic                 done,
	output logic signed [UW-1:0] ux,
	output logic signed [UW-1:0] uy,
	output logic signed [UW-1:0] uz,
	output logic                 zero
);

	localparam int D = DIV_STAGES;

	logic [31:0]  rem_s [1:D][0:2];
	logic [D-1:0] quo_s [1:D][0:2];
	logic [31:0]  m_s [1:D];
	axis_t        side_s [1:D];
	logic         vld_s [1:D];

	logic signed [15:0] comp [0:2];
	logic signed [15:0] compo [0:2];
	logic signed [UW-1:0] u [0:2];

	assign comp[0]  = side.x;
	assign comp[1]  = side.y;
	assign comp[2]  = side.z;
	assign compo[0] = side_s[D].x;
	assign compo[1] = side_s[D].y;
	assign compo[2] = side_s[D].z;

	// restoring divide of |a| * 2^45 by the length, one quotient bit per stage
	for (genvar j = 0; j < D; j++) begin : g_st
		logic [31:0] mm;
		axis_t       sd;
		logic        vv;
		if (j == 0) begin : g_first
			assign mm = m;
			assign sd = side;
			assign vv = start;
		end else begin : g_next
			assign mm = m_s[j];
			assign sd = side_s[j];
			assign vv = vld_s[j];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[j+1] <= 1'b0;
			else
				vld_s[j+1] <= vv;
		end

		always_ff @(posedge clk) begin
			m_s[j+1]    <= mm;
			side_s[j+1] <= sd;
		end

		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic [31:0]  rr;
			logic [D-1:0] qq;
			logic [32:0]  sh;
			if (j == 0) begin : g_first
				logic [15:0] mag;
				assign mag = comp[l][15] ? 16'(-comp[l]) : 16'(comp[l]);
				assign rr  = {2'b0, mag, 14'b0};
				assign qq  = '0;
			end else begin : g_next
				assign rr = rem_s[j][l];
				assign qq = quo_s[j][l];
			end
			assign sh = {rr, 1'b0};

			always_ff @(posedge clk) begin
				if (sh >= {1'b0, mm}) begin
					rem_s[j+1][l] <= 32'(sh - {1'b0, mm});
					quo_s[j+1][l] <= {qq[D-2:0], 1'b1};
				end else begin
					rem_s[j+1][l] <= sh[31:0];
					quo_s[j+1][l] <= {qq[D-2:0], 1'b0};
				end
			end
		end
	end

	// apply the component sign, truncation toward zero
	for (genvar l = 0; l < 3; l++) begin : g_sign
		logic signed [UW-1:0] uq;
		assign uq   = $signed(UW'(quo_s[D][l]));
		assign u[l] = compo[l][15] ? -uq : uq;
	end

	assign done = vld_s[D];
	assign ux   = u[0];
	assign uy   = u[1];
	assign uz   = u[2];
	assign zero = side_s[D].zero;

endmodule

### sv/aarm_matrix.sv
module aarm_matrix import aarm_pkg::*; #(
	parameter int OUT_FRAC_BITS = OUT_FRAC_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [UW-1:0] ux,
	input  logic signed [UW-1:0] uy,
	input  logic signed [UW-1:0] uz,
	input  logic signed [CW-1:0] cosv,
	input  logic signed [CW-1:0] sinv,
	input  logic                 zero,
	output logic                 done,
	output logic signed [15:0]   row0_col0,
	output logic signed [15:0]   row0_col1,
	output logic signed [15:0]   row0_col2,
	output logic signed [15:0]   row1_col0,
	output logic signed [15:0]   row1_col1,
	output logic signed [15:0]   row1_col2,
	output logic signed [15:0]   row2_col0,
	output logic signed [15:0]   row2_col1,
	output logic signed [15:0]   row2_col2,
	output logic                 zero_axis
);

	// first stage: axis products, axis times sine and one minus cosine
	logic signed [2*UW-1:0]  pxx, pyy, pzz, pxy, pyz, pzx;
	logic signed [UW+CW-1:0] pxs, pys, pzs;
	logic signed [CW-1:0]    xx_s1, yy_s1, zz_s1, xy_s1, yz_s1, zx_s1;
	logic signed [CW-1:0]    xs_s1, ys_s1, zs_s1, c_s1;
	logic signed [OW-1:0]    oc_s1;
	logic                    zero_s1, vld_s1;

	assign pxx = ux * ux;
	assign pyy = uy * uy;
	assign pzz = uz * uz;
	assign pxy = ux * uy;
	assign pyz = uy * uz;
	assign pzx = uz * ux;
	assign pxs = ux * sinv;
	assign pys = uy * sinv;
	assign pzs = uz * sinv;

	always_ff @(posedge clk) begin
		xx_s1   <= pxx[CW+29:30];
		yy_s1   <= pyy[CW+29:30];
		zz_s1   <= pzz[CW+29:30];
		xy_s1   <= pxy[CW+29:30];
		yz_s1   <= pyz[CW+29:30];
		zx_s1   <= pzx[CW+29:30];
		xs_s1   <= pxs[CW+29:30];
		ys_s1   <= pys[CW+29:30];
		zs_s1   <= pzs[CW+29:30];
		c_s1    <= cosv;
		oc_s1   <= QONE_O - OW'(cosv);
		zero_s1 <= zero;
	end

	// second stage: scale by one minus cosine
	logic signed [OW+CW-1:0] qxx, qyy, qzz, qxy, qyz, qzx;
	logic signed [CW-1:0]    xx_s2, yy_s2, zz_s2, xy_s2, yz_s2, zx_s2;
	logic signed [CW-1:0]    xs_s2, ys_s2, zs_s2, c_s2;
	logic                    zero_s2, vld_s2;

	assign qxx = oc_s1 * xx_s1;
	assign qyy = oc_s1 * yy_s1;
	assign qzz = oc_s1 * zz_s1;
	assign qxy = oc_s1 * xy_s1;
	assign qyz = oc_s1 * yz_s1;
	assign qzx = oc_s1 * zx_s1;

	always_ff @(posedge clk) begin
		xx_s2   <= qxx[CW+29:30];
		yy_s2   <= qyy[CW+29:30];
		zz_s2   <= qzz[CW+29:30];
		xy_s2   <= qxy[CW+29:30];
		yz_s2   <= qyz[CW+29:30];
		zx_s2   <= qzx[CW+29:30];
		xs_s2   <= xs_s1;
		ys_s2   <= ys_s1;
		zs_s2   <= zs_s1;
		c_s2    <= c_s1;
		zero_s2 <= zero_s1;
	end

	// third stage: add the cosine and sine terms, round and saturate, or give the identity for a zero axis
	logic signed [15:0] one_out;

	assign one_out = to_out(QONE_E, OUT_FRAC_BITS);

	always_ff @(posedge clk) begin
		if (zero_s2) begin
			row0_col0 <= one_out;
			row0_col1 <= '0;
			row0_col2 <= '0;
			row1_col0 <= '0;
			row1_col1 <= one_out;
			row1_col2 <= '0;
			row2_col0 <= '0;
			row2_col1 <= '0;
			row2_col2 <= one_out;
		end else begin
			row0_col0 <= to_out(EW'(xx_s2) + EW'(c_s2), OUT_FRAC_BITS);
			row0_col1 <= to_out(EW'(xy_s2) - EW'(zs_s2), OUT_FRAC_BITS);
			row0_col2 <= to_out(EW'(zx_s2) + EW'(ys_s2), OUT_FRAC_BITS);
			row1_col0 <= to_out(EW'(xy_s2) + EW'(zs_s2), OUT_FRAC_BITS);
			row1_col1 <= to_out(EW'(yy_s2) + EW'(c_s2), OUT_FRAC_BITS);
			row1_col2 <= to_out(EW'(yz_s2) - EW'(xs_s2), OUT_FRAC_BITS);
			row2_col0 <= to_out(EW'(zx_s2) - EW'(ys_s2), OUT_FRAC_BITS);
			row2_col1 <= to_out(EW'(yz_s2) + EW'(xs_s2), OUT_FRAC_BITS);
			row2_col2 <= to_out(EW'(zz_s2) + EW'(c_s2), OUT_FRAC_BITS);
		end
		zero_axis <= zero_s2;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			done   <= vld_s2;
		end
	end

endmodule

### bench/axis_angle_rotation_matrix_check.sv
`timescale 1ns / 1ps
module axis_angle_rotation_matrix_check (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic signed [15:0] angle,
	input  logic signed [15:0] axis_x,
	input  logic signed [15:0] axis_y,
	input  logic signed [15:0] axis_z,
	input  logic               done,
	input  logic signed [15:0] row0_col0,
	input  logic signed [15:0] row0_col1,
	input  logic signed [15:0] row0_col2,
	input  logic signed [15:0] row1_col0,
	input  logic signed [15:0] row1_col1,
	input  logic signed [15:0] row1_col2,
	input  logic signed [15:0] row2_col0,
	input  logic signed [15:0] row2_col1,
	input  logic signed [15:0] row2_col2,
	input  logic               zero_axis,
	output int                 fail_count,
	output int                 pending
);

	localparam int N_ITER = 16;
	localparam int N_FRAC = 14;
	localparam longint ONE_Q30 = 64'sd1073741824;
	localparam longint PI_Q30 = 64'sd3373259426;
	localparam longint TWO_PI_Q30 = 64'sd6746518852;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint GAIN_Q30 = 64'sd652032874;

	typedef struct {
		logic signed [15:0] ent[9];
		logic               zero;
	} matrix_t;

	matrix_t matrix_q[$];

	longint arctan_q30[16] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
		64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
		64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
		64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF};

	// q.30 product floored back to q.30 (>>> is a floor shift on signed)
	function automatic longint qmul30(longint a, longint b);
		return (a * b) >>> 30;
	endfunction

	function automatic logic signed [15:0] round_sat(longint v);
		longint lim;
		lim = longint'(1) << N_FRAC;
		v = (v + (longint'(1) << (29 - N_FRAC))) >>> (30 - N_FRAC);
		if (v > lim) v = lim;
		if (v < -lim) v = -lim;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[15:0];
	endfunction

	function automatic longint root64(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return longint'(r);
	endfunction

	function automatic matrix_t rotation_of(logic signed [15:0] a, logic signed [15:0] x,
			logic signed [15:0] y, logic signed [15:0] z);
		matrix_t r;
		longint th, cx, cy, dx, dy, c, s, m, ux, uy, uz, oc;
		longint xx, yy, zz, xy, yz, zx, xs, ys, zs, ax, ay, az;
		longint unsigned q;
		bit negc;
		th = longint'(a) * 262144;
		negc = 0;
		// reduce to [-pi, pi] then fold into [-pi/2, pi/2]
		for (int k = 0; k < 2; k++) begin
			if (th > PI_Q30) th -= TWO_PI_Q30;
			if (th < -PI_Q30) th += TWO_PI_Q30;
		end
		if (th > HALF_PI_Q30) begin
			th = PI_Q30 - th;
			negc = 1;
		end else if (th < -HALF_PI_Q30) begin
			th = -PI_Q30 - th;
			negc = 1;
		end
		// rotation-mode cordic
		cx = GAIN_Q30;
		cy = 0;
		for (int i = 0; i < N_ITER; i++) begin
			dx = cy >>> i;
			dy = cx >>> i;
			if (th >= 0) begin
				cx -= dx; cy += dy; th -= arctan_q30[i];
			end else begin
				cx += dx; cy -= dy; th += arctan_q30[i];
			end
		end
		c = negc ? -cx : cx;
		s = cy;
		ax = x; ay = y; az = z;
		q = ax * ax + ay * ay + az * az;
		if (q == 0) begin
			foreach (r.ent[k]) r.ent[k] = (k % 4 == 0) ? round_sat(ONE_Q30) : 16'sd0;
			r.zero = 1;
			return r;
		end
		m = root64(q << 30);
		ux = (ax * (longint'(1) << 45)) / m;
		uy = (ay * (longint'(1) << 45)) / m;
		uz = (az * (longint'(1) << 45)) / m;
		oc = ONE_Q30 - c;
		xx = qmul30(ux, ux); yy = qmul30(uy, uy); zz = qmul30(uz, uz);
		xy = qmul30(ux, uy); yz = qmul30(uy, uz); zx = qmul30(uz, ux);
		xs = qmul30(ux, s); ys = qmul30(uy, s); zs = qmul30(uz, s);
		r.ent[0] = round_sat(qmul30(oc, xx) + c);
		r.ent[1] = round_sat(qmul30(oc, xy) - zs);
		r.ent[2] = round_sat(qmul30(oc, zx) + ys);
		r.ent[3] = round_sat(qmul30(oc, xy) + zs);
		r.ent[4] = round_sat(qmul30(oc, yy) + c);
		r.ent[5] = round_sat(qmul30(oc, yz) - xs);
		r.ent[6] = round_sat(qmul30(oc, zx) - ys);
		r.ent[7] = round_sat(qmul30(oc, yz) + xs);
		r.ent[8] = round_sat(qmul30(oc, zz) + c);
		r.zero = 0;
		return r;
	endfunction

	initial fail_count = 0;
	initial pending = 0;

	// predict on accepted input, compare on each result
	always @(posedge clk) begin
		matrix_t e;
		logic signed [15:0] got[9];
		bit bad;
		if (arst_n) begin
			if (done) begin
				got = '{row0_col0, row0_col1, row0_col2, row1_col0, row1_col1,
					row1_col2, row2_col0, row2_col1, row2_col2};
				if (matrix_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result transaction at %0t", $realtime);
				end else begin
					e = matrix_q.pop_front();
					bad = (zero_axis !== e.zero);
					foreach (got[k]) if (got[k] !== e.ent[k]) bad = 1;
					if (bad) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("mismatch at %0t: zero_axis exp %0d got %0d",
								$realtime, e.zero, zero_axis);
							foreach (got[k])
								$display("  entry %0d exp %0d got %0d", k, e.ent[k], got[k]);
						end
					end
				end
			end
			if (start && !busy)
				matrix_q.push_back(rotation_of(angle, axis_x, axis_y, axis_z));
		end
		pending <= matrix_q.size();
	end

endmodule

### bench/axis_angle_rotation_matrix_test.sv
`timescale 1ns / 1ps
module axis_angle_rotation_matrix_test;

	localparam int LATENCY = 67;
	localparam int N_RANDOM = 1300;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy, done, zero_axis;
	logic signed [15:0] angle = 0, axis_x = 0, axis_y = 0, axis_z = 0;
	logic signed [15:0] row0_col0, row0_col1, row0_col2, row1_col0, row1_col1;
	logic signed [15:0] row1_col2, row2_col0, row2_col1, row2_col2;
	int fail_count, pending;

	always #2 clk = ~clk;

	axis_angle_rotation_matrix dut (.*);
	axis_angle_rotation_matrix_check checker_i (.*);

	// random field: edges, tiny values or full range
	function automatic logic signed [15:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'(int'($urandom_range(0, 6)) - 3);
			3: return 16'sd0;
			default: return 16'($urandom());
		endcase
	endfunction

	// one transaction, with a random idle gap before it unless quiet
	task automatic issue(logic signed [15:0] a, logic signed [15:0] x,
			logic signed [15:0] y, logic signed [15:0] z, bit quiet);
		if (!quiet)
			while ($urandom_range(0, 99) < 29) begin
				start <= 0;
				@(posedge clk);
			end
		start <= 1;
		angle <= a;
		axis_x <= x;
		axis_y <= y;
		axis_z <= z;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	initial begin
		int spins;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: angle extremes, quadrant folds, zero and extreme axes
		issue(16'sd0, 16'sd0, 16'sd0, 16'sd0, 1);
		issue(16'sh7FFF, 16'sd0, 16'sd0, 16'sd0, 1);
		issue(16'sh7FFF, 16'sd1, 16'sd0, 16'sd0, 1);
		issue(16'sh8000, 16'sd0, 16'sd1, 16'sd0, 1);
		issue(16'sd6434, 16'sd0, 16'sd0, 16'sd1, 1);
		issue(-16'sd6434, 16'sd0, 16'sd0, -16'sd1, 1);
		issue(16'sd12868, 16'sd1, 16'sd1, 16'sd1, 1);
		issue(-16'sd12868, 16'sh8000, 16'sh8000, 16'sh8000, 1);
		issue(16'sd25736, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1);
		issue(16'sd3217, 16'sh7FFF, 16'sh8000, 16'sd0, 1);
		issue(16'sd9651, -16'sd1, 16'sd2, -16'sd3, 1);
		issue(16'sd1, 16'sh8000, 16'sd0, 16'sd0, 1);
		issue(-16'sd1, 16'sd0, 16'sh7FFF, 16'sd0, 1);
		issue(16'sd19302, 16'sd3, 16'sd4, 16'sd0, 1);
		issue(16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 1);
		issue(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 1);
		// random, with a burst stretch of back-to-back transactions
		for (int n = 0; n < N_RANDOM; n++)
			issue(16'($urandom()), pick_word(), pick_word(), pick_word(),
				n >= 400 && n < 600);
		start <= 0;
		spins = 0;
		while (pending != 0 && spins < 10000) begin
			@(posedge clk);
			spins++;
		end
		repeat (LATENCY + 10) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#200000;
		$display("simulation failed");
		$finish;
	end

endmodule
